// File: design/sias_pkg.sv
// ----------------------------------------------------------------------------
// sias_pkg
// Shared types and constants for the sorted insertion buffer.
// ----------------------------------------------------------------------------
package sias_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int SUM_W   = 40;
    localparam int OUT_W   = 48;

    localparam logic signed [63:0] SUM_MAX = 64'sd549755813887;
    localparam logic signed [63:0] SUM_MIN = -64'sd549755813888;

    typedef struct packed {
        logic take_in;
        logic insert;
        logic sum_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic sum_last;
    } t_sts;

endpackage

// File: design/sias_ctrl.sv
// ----------------------------------------------------------------------------
// sias_ctrl
// Sequencer: accept, insert, summing pass, result hand-off.
// ----------------------------------------------------------------------------
module sias_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_free,
    input  sias_pkg::t_sts i_sts,
    output sias_pkg::t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_INSERT = 2'd1;
    localparam logic [1:0] ST_SUM    = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.take_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_sts.sum_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/sias_dp.sv
// ----------------------------------------------------------------------------
// sias_dp
// Row of sorted cells with parallel compare/shift, and a rotating sum pass.
// ----------------------------------------------------------------------------
module sias_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [sias_pkg::VALUE_W-1:0] i_value,
    input  sias_pkg::t_cmd                      i_cmd,
    output sias_pkg::t_sts                      o_sts,
    output logic                                o_overflow,
    output logic [sias_pkg::COUNT_W-1:0]        o_count,
    output logic signed [sias_pkg::SUM_W-1:0]   o_sum
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ACC_W = (33 + IDX_W > 41) ? 33 + IDX_W : 41;
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(sias_pkg::SUM_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(sias_pkg::SUM_MIN);

    logic signed [sias_pkg::VALUE_W-1:0] r_cell [CAPACITY];
    logic signed [sias_pkg::VALUE_W-1:0] r_val;
    logic [CNT_W-1:0]                    r_count;
    logic [IDX_W-1:0]                    r_idx;
    logic signed [ACC_W-1:0]             r_acc;
    logic                                r_ovf;
    logic [CAPACITY-1:0]                 w_ge;
    logic                                w_full;
    logic signed [ACC_W-1:0]             w_term;
    logic signed [ACC_W-1:0]             w_sat;
    logic [CNT_W+sias_pkg::COUNT_W-1:0]  w_cnt_wide;

    assign w_full = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_ge[i] = (CNT_W'(i) < r_count) && (r_val <= r_cell[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && !w_full) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (w_ge[i]) begin
                    if (i == 0) begin
                        r_cell[i] <= r_val;
                    end else if (!w_ge[(i > 0) ? i - 1 : 0]) begin
                        r_cell[i] <= r_val;
                    end else begin
                        r_cell[i] <= r_cell[(i > 0) ? i - 1 : 0];
                    end
                end else if (CNT_W'(i) == r_count) begin
                    if (i > 0 && w_ge[(i > 0) ? i - 1 : 0]) begin
                        r_cell[i] <= r_cell[(i > 0) ? i - 1 : 0];
                    end else begin
                        r_cell[i] <= r_val;
                    end
                end
            end
        end else if (i_cmd.sum_step) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_cell[i] <= r_cell[(i + 1) % CAPACITY];
            end
        end
    end

    assign w_term = ACC_W'(r_cell[0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_val <= i_value;
        end
        if (i_cmd.insert) begin
            r_ovf <= w_full;
            r_acc <= '0;
        end else if (i_cmd.sum_step && (CNT_W'(r_idx) < r_count)) begin
            r_acc <= r_idx[0] ? r_acc + w_term : r_acc - w_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.insert) begin
                r_idx <= '0;
                if (!w_full) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end else if (i_cmd.sum_step) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    assign o_sts.full     = w_full;
    assign o_sts.sum_last = (r_idx == IDX_W'(CAPACITY - 1));

    assign w_sat = (r_acc > ACC_MAX) ? ACC_MAX : ((r_acc < ACC_MIN) ? ACC_MIN : r_acc);
    assign w_cnt_wide = {{sias_pkg::COUNT_W{1'b0}}, r_count};

    assign o_overflow = r_ovf;
    assign o_count    = w_cnt_wide[sias_pkg::COUNT_W-1:0];
    assign o_sum      = w_sat[sias_pkg::SUM_W-1:0];

endmodule

// File: design/sorted_insert_alternating_sum.sv
// ----------------------------------------------------------------------------
// sorted_insert_alternating_sum
// Sorted insertion buffer reporting count and alternating sum per value.
// ----------------------------------------------------------------------------
// Input stream: i_s_tdata carries one signed s15.16 value per transaction.
// The value is inserted in ascending order into a row of CAPACITY cells
// (all cells compare and shift in parallel). If the row is full the value
// is dropped and the overflow bit of the result is set.
// Output stream: one result per input: overflow, count held, and the
// saturated alternating sum (even positions subtracted, odd added), s23.16.
// The sum is formed by rotating the cell row once past a single accumulator,
// one cell per cycle.
// A finished result sits in an output register; the next value is accepted
// while it waits. If the receiver stalls, the block holds the next result
// until the register frees. Reset empties the store and clears the output.
// ----------------------------------------------------------------------------
module sorted_insert_alternating_sum #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // [0] overflow, [7:1] count, [47:8] alternating_sum
);

    sias_pkg::t_cmd                    w_cmd;
    sias_pkg::t_sts                    w_sts;
    logic                              w_ovf;
    logic [sias_pkg::COUNT_W-1:0]      w_count;
    logic signed [sias_pkg::SUM_W-1:0] w_sum;
    logic                              w_out_free;
    logic                              r_m_valid;
    logic [sias_pkg::OUT_W-1:0]        r_m_data;

    assign w_out_free = !r_m_valid || i_m_tready;

    sias_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sias_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (i_s_tdata),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_overflow (w_ovf),
        .o_count    (w_count),
        .o_sum      (w_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_cmd.load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.load_out) begin
            r_m_data <= {w_sum, w_count, w_ovf};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

// File: design/sias_checker.sv
// ----------------------------------------------------------------------------
// sias_checker
// Port-level checks for the sorted insertion buffer.
// ----------------------------------------------------------------------------
module sias_checker #(
    parameter int CAPACITY = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second transaction taken while busy");

    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[7:1] == 7'd0 && CAPACITY < 128 |-> o_m_tdata[47:8] == 40'd0)
        else $error("empty store with nonzero sum");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> o_m_tdata[7:1] == 7'(CAPACITY))
        else $error("overflow without full store");

endmodule

bind sorted_insert_alternating_sum sias_checker #(.CAPACITY(CAPACITY)) u_sias_checker (.*);
